FILE: hw/rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Console geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;
    localparam int CELLS     = ROWS * COLUMNS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TAB_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    // Opcodes
    localparam logic [1:0] OPC_PUT   = 2'd0;
    localparam logic [1:0] OPC_ERASE = 2'd1;
    localparam logic [1:0] OPC_CLEAR = 2'd2;
    localparam logic [1:0] OPC_READ  = 2'd3;

    // Special characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam logic [7:0] RESET_ATTR       = 8'h07;
    localparam logic [7:0] RESET_CLEAR_ATTR = 8'h09;

    // Configuration register indexes
    localparam logic REG_CLEAR_ATTR = 1'b0;
    localparam logic REG_ERASE_ATTR = 1'b1;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_TAB,
        CMD_ERASE,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       char_code;
        logic [7:0]       attribute;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
        logic             read_ok;
        logic             cursor_enable;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [LIN_W-1:0] cursor_linear;
        logic             cursor_write;
        logic             scrolled;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attribute;
    } result_t;

    // Physical cell address of a logical (row, col); top is the physical row
    // that currently shows as logical row 0.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] top
    );
        logic [ROW_W:0] phys;
        phys = {1'b0, row} + {1'b0, top};
        if (phys >= (ROW_W+1)'(ROWS))
        begin
            phys = phys - (ROW_W+1)'(ROWS);
        end
        return ADDR_W'(32'(phys) * COLUMNS + 32'(col));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_front.sv
`default_nettype none

module tcw_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [1:0]       opcode,
    input  wire logic [7:0]       char_code,
    input  wire logic [7:0]       attribute,
    input  wire logic [4:0]       read_row,
    input  wire logic [6:0]       read_col,
    input  wire logic             cursor_enable,
    output logic                  q_full,
    output logic                  cmd_valid,
    output tcw_pkg::cmd_t         cmd,
    input  wire logic             cmd_pop
);
    import tcw_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       classified;

    // Classify the incoming beat
    always_comb
    begin
        classified.char_code     = char_code;
        classified.attribute     = attribute;
        classified.read_row      = read_row;
        classified.read_col      = read_col;
        classified.cursor_enable = cursor_enable;
        classified.read_ok       = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
        unique case (opcode)
            OPC_PUT:
            begin
                if (char_code == CH_LF || char_code == CH_CR)
                begin
                    classified.kind = CMD_NEWLINE;
                end
                else if (char_code == CH_TAB)
                begin
                    classified.kind = CMD_TAB;
                end
                else
                begin
                    classified.kind = CMD_PUT;
                end
            end
            OPC_ERASE: classified.kind = CMD_ERASE;
            OPC_CLEAR: classified.kind = CMD_CLEAR;
            OPC_READ:  classified.kind = CMD_READ;
            default:   classified.kind = CMD_READ;
        endcase
    end

    assign q_full    = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (take)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (take && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!take && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_back.sv
`default_nettype none

module tcw_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic          cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          cmd_valid,
    input  tcw_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               booting,
    input  wire logic          out_full,
    output logic               out_push,
    output tcw_pkg::result_t   result
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_TAB    = 5'b00010,
        S_FILL   = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [TAB_W-1:0]  tab_cnt_reg, tab_cnt_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] fill_end_reg, fill_end_next;
    logic [7:0]        fill_attr_reg, fill_attr_next;
    logic              booting_reg, booting_next;
    logic [7:0]        attr_reg, attr_next;
    logic              res_cwrite_reg, res_cwrite_next;
    logic              res_scrolled_reg, res_scrolled_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic [7:0]        clear_attr_reg;
    logic [7:0]        erase_attr_reg;

    // Cell store: attribute in the high byte, character in the low byte
    logic [15:0]       cells_mem [CELLS];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // End-of-put wrap / scroll handling
    logic              fin_go;
    logic [COL_W:0]    fin_col;
    logic [ROW_W:0]    fin_row;
    logic [7:0]        fin_attr;
    logic [COL_W:0]    wrap_col;
    logic [ROW_W:0]    wrap_row;
    logic [ADDR_W-1:0] scroll_base;

    assign booting = booting_reg;
    assign scroll_base = cell_addr('0, '0, top_reg);

    assign result.cursor_col     = col_reg;
    assign result.cursor_row     = row_reg;
    assign result.cursor_linear  = LIN_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign result.cursor_write   = res_cwrite_reg;
    assign result.scrolled       = res_scrolled_reg;
    assign result.cell_char      = res_char_reg;
    assign result.cell_attribute = res_attr_reg;

    always_comb
    begin
        state_next        = state_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        top_next          = top_reg;
        tab_cnt_next      = tab_cnt_reg;
        fill_addr_next    = fill_addr_reg;
        fill_end_next     = fill_end_reg;
        fill_attr_next    = fill_attr_reg;
        booting_next      = booting_reg;
        attr_next         = attr_reg;
        res_cwrite_next   = res_cwrite_reg;
        res_scrolled_next = res_scrolled_reg;
        res_char_next     = res_char_reg;
        res_attr_next     = res_attr_reg;
        mem_we            = 1'b0;
        mem_waddr         = cell_addr(row_reg, col_reg, top_reg);
        mem_wdata         = {attr_reg, CH_BLANK};
        mem_raddr         = cell_addr(cmd.read_row, cmd.read_col, top_reg);
        cmd_pop           = 1'b0;
        out_push          = 1'b0;
        fin_go            = 1'b0;
        fin_col           = {1'b0, col_reg};
        fin_row           = {1'b0, row_reg};
        fin_attr          = attr_reg;
        wrap_col          = '0;
        wrap_row          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop           = 1'b1;
                    attr_next         = cmd.attribute;
                    fin_attr          = cmd.attribute;
                    res_cwrite_next   = cmd.cursor_enable;
                    res_scrolled_next = 1'b0;
                    res_char_next     = '0;
                    res_attr_next     = '0;
                    unique case (cmd.kind)
                        CMD_NEWLINE:
                        begin
                            fin_go  = 1'b1;
                            fin_col = '0;
                            fin_row = {1'b0, row_reg} + 1'b1;
                        end
                        CMD_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {cmd.attribute, cmd.char_code};
                            fin_go    = 1'b1;
                            fin_col   = {1'b0, col_reg} + 1'b1;
                        end
                        CMD_TAB:
                        begin
                            tab_cnt_next = '0;
                            state_next   = S_TAB;
                        end
                        CMD_ERASE:
                        begin
                            if (col_reg == '0 && row_reg == '0)
                            begin
                                res_cwrite_next = 1'b0;
                            end
                            else
                            begin
                                if (col_reg == '0)
                                begin
                                    col_next = COL_W'(COLUMNS - 1);
                                    row_next = row_reg - 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(row_next, col_next, top_reg);
                                mem_wdata = {erase_attr_reg, CH_BLANK};
                            end
                            state_next = S_RESULT;
                        end
                        CMD_CLEAR:
                        begin
                            fill_addr_next = '0;
                            fill_end_next  = ADDR_W'(CELLS - 1);
                            fill_attr_next = clear_attr_reg;
                            top_next       = '0;
                            col_next       = '0;
                            row_next       = '0;
                            state_next     = S_FILL;
                        end
                        CMD_READ:
                        begin
                            // a read never writes the cursor location register
                            res_cwrite_next = 1'b0;
                            state_next      = cmd.read_ok ? S_READ : S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_TAB:
            begin
                mem_we       = 1'b1;
                col_next     = col_reg + 1'b1;
                tab_cnt_next = tab_cnt_reg + 1'b1;
                if (32'(tab_cnt_reg) == TAB_WIDTH - 1 || 32'(col_reg) == COLUMNS - 1)
                begin
                    fin_go  = 1'b1;
                    fin_col = {1'b0, col_reg} + 1'b1;
                end
            end
            S_FILL:
            begin
                mem_we         = 1'b1;
                mem_waddr      = fill_addr_reg;
                mem_wdata      = {fill_attr_reg, CH_BLANK};
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == fill_end_reg)
                begin
                    booting_next = 1'b0;
                    state_next   = booting_reg ? S_IDLE : S_RESULT;
                end
            end
            S_READ:
            begin
                res_char_next = rdata_reg[7:0];
                res_attr_next = rdata_reg[15:8];
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Column wrap, then scroll when the row runs off the bottom
        if (fin_go)
        begin
            if (fin_col == (COL_W+1)'(COLUMNS))
            begin
                wrap_col = '0;
                wrap_row = fin_row + 1'b1;
            end
            else
            begin
                wrap_col = fin_col;
                wrap_row = fin_row;
            end
            col_next = wrap_col[COL_W-1:0];
            if (wrap_row == (ROW_W+1)'(ROWS))
            begin
                row_next          = ROW_W'(ROWS - 1);
                top_next          = (32'(top_reg) == ROWS - 1) ? '0 : top_reg + 1'b1;
                fill_addr_next    = scroll_base;
                fill_end_next     = scroll_base + ADDR_W'(COLUMNS - 1);
                fill_attr_next    = fin_attr;
                res_scrolled_next = 1'b1;
                state_next        = S_FILL;
            end
            else
            begin
                row_next   = wrap_row[ROW_W-1:0];
                state_next = S_RESULT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FILL;
            col_reg          <= '0;
            row_reg          <= '0;
            top_reg          <= '0;
            tab_cnt_reg      <= '0;
            fill_addr_reg    <= '0;
            fill_end_reg     <= ADDR_W'(CELLS - 1);
            fill_attr_reg    <= RESET_ATTR;
            booting_reg      <= 1'b1;
            res_cwrite_reg   <= 1'b0;
            res_scrolled_reg <= 1'b0;
            clear_attr_reg   <= RESET_CLEAR_ATTR;
            erase_attr_reg   <= RESET_ATTR;
        end
        else
        begin
            state_reg        <= state_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            top_reg          <= top_next;
            tab_cnt_reg      <= tab_cnt_next;
            fill_addr_reg    <= fill_addr_next;
            fill_end_reg     <= fill_end_next;
            fill_attr_reg    <= fill_attr_next;
            booting_reg      <= booting_next;
            res_cwrite_reg   <= res_cwrite_next;
            res_scrolled_reg <= res_scrolled_next;
            if (cfg_write && cfg_index == REG_CLEAR_ATTR)
            begin
                clear_attr_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_ERASE_ATTR)
            begin
                erase_attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        attr_reg      <= attr_next;
        res_char_reg  <= res_char_next;
        res_attr_reg  <= res_attr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cells_mem[mem_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_out_queue.sv
`default_nettype none

module tcw_out_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         out_push,
    input  tcw_pkg::result_t  result,
    output logic              out_full,
    output logic              empty,
    input  wire logic         pop,
    output tcw_pkg::result_t  head
);
    import tcw_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       take_out;

    assign out_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = slot_reg[rd_ptr_reg];
    assign take_out = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (out_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (take_out)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (out_push && !take_out)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!out_push && take_out)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            slot_reg[wr_ptr_reg] <= result;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// Timing: the cell store takes one write per cycle, so a tab writes up to TAB_WIDTH
//   blanks, a scroll rewrites the new bottom row (COLUMNS cells) and a clear all
//   ROWS * COLUMNS cells. The sequencer takes one item at a time; the two-entry
//   command queue can take further items while it works.
// Reset: asynchronous, active low; afterwards the store is blanked (spaces,
//   attribute 7), during which full stays high.
`default_nettype none

module text_console_writer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input queue side
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] attribute,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    input  wire logic       cursor_enable,
    // result queue side
    output logic            empty,
    input  wire logic       pop,
    output logic [6:0]      cursor_col,
    output logic [4:0]      cursor_row,
    output logic [10:0]     cursor_linear,
    output logic            cursor_write,
    output logic            scrolled,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_attribute,
    // configuration writes
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);
    import tcw_pkg::*;

    logic    q_full;
    logic    take;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    logic    booting;
    logic    out_full;
    logic    out_push;
    result_t result;
    result_t head;

    // No beats taken while the store is being blanked after reset
    assign full = q_full || booting;
    assign take = push && !full;

    // Front: classifies each beat (newline / tab / char / erase / clear / read)
    // into a two-entry command queue.
    tcw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .opcode        (opcode),
        .char_code     (char_code),
        .attribute     (attribute),
        .read_row      (read_row),
        .read_col      (read_col),
        .cursor_enable (cursor_enable),
        .q_full        (q_full),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // Back: cursor, cell store and sequencer. Scrolling rotates a top-row
    // pointer, so only the new bottom row is rewritten.
    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .booting   (booting),
        .out_full  (out_full),
        .out_push  (out_push),
        .result    (result)
    );

    // Result queue decouples the back end from the consumer
    tcw_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .out_push (out_push),
        .result   (result),
        .out_full (out_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign cursor_col     = head.cursor_col;
    assign cursor_row     = head.cursor_row;
    assign cursor_linear  = head.cursor_linear;
    assign cursor_write   = head.cursor_write;
    assign scrolled       = head.scrolled;
    assign cell_char      = head.cell_char;
    assign cell_attribute = head.cell_attribute;

endmodule

`default_nettype wire
